[rtl/min_queue_two_stacks_top_defines.svh]
// ---------------------------------------------------------------------------
// min_queue_two_stacks_top_defines
// Assertion macros shared by the min queue RTL.
// ---------------------------------------------------------------------------
`ifndef MIN_QUEUE_TWO_STACKS_TOP_DEFINES_SVH
`define MIN_QUEUE_TWO_STACKS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MQTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MQTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mqts_pkg.sv]
// ---------------------------------------------------------------------------
// mqts_pkg
// Types and codes for the min queue built from two min stacks.
// ---------------------------------------------------------------------------
package mqts_pkg;

  localparam logic [2:0] CMD_ENQUEUE = 3'd0;
  localparam logic [2:0] CMD_DEQUEUE = 3'd1;
  localparam logic [2:0] CMD_FRONT   = 3'd2;
  localparam logic [2:0] CMD_SIZE    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_MIN     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
  } out_item_t;

  // one stack entry: the value and the minimum of it and everything below
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] minimum;
  } entry_t;

endpackage

[rtl/min_queue_two_stacks_top.sv]
// ---------------------------------------------------------------------------
// min_queue_two_stacks_top
// FIFO of signed 32-bit values with a minimum query, built on two min stacks.
// ---------------------------------------------------------------------------
// One command is taken at a time and gives one result beat. Enqueue, size,
// clear, unknown codes, errors and a min with an empty output stack go from
// idle straight to the done state; front, dequeue and min that read the output
// stack pass through the read and response states first, for the registered
// read of the stack memory. When front or dequeue finds the output stack empty,
// a transfer first moves the input stack across at one element per cycle
// through the input stack read port. A finished result sits in an output
// register, so the next command is taken while it waits. No clearing pass is
// needed after reset; the stacks are tracked by their fill counts.
`include "min_queue_two_stacks_top_defines.svh"

module min_queue_two_stacks_top #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mqts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mqts_pkg::out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XFER = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic [2:0]         op;
  logic [CW-1:0]      in_count;
  logic [CW-1:0]      out_count;
  logic [CW-1:0]      total;
  logic signed [31:0] in_min;
  logic signed [31:0] xfer_min;
  logic               rd_pending;
  logic [1:0]         res_status;
  logic signed [31:0] res_value;

  logic               in_we;
  logic [AW-1:0]      in_raddr;
  mqts_pkg::entry_t   in_wdata;
  mqts_pkg::entry_t   in_rdata;
  logic               out_we;
  logic [AW-1:0]      out_raddr;
  mqts_pkg::entry_t   out_wdata;
  mqts_pkg::entry_t   out_rdata;

  logic signed [31:0] min_a;
  logic signed [31:0] min_b;
  logic signed [31:0] min_y;
  logic               accept;
  logic               res_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res_free = !out_valid || !out_stall;
  assign total    = in_count + out_count;

  always_comb begin
    unique case (state)
      S_IDLE: begin
        min_a = in_min;
        min_b = in_item.value_in;
      end
      S_XFER: begin
        min_a = xfer_min;
        min_b = in_rdata.value;
      end
      default: begin
        min_a = in_min;
        min_b = out_rdata.minimum;
      end
    endcase
  end

  mqts_min_unit u_min (
    .a(min_a),
    .b(min_b),
    .y(min_y)
  );

  // memory port control
  always_comb begin
    in_we             = 1'b0;
    in_wdata.value    = in_item.value_in;
    in_wdata.minimum  = (in_count == '0) ? in_item.value_in : min_y;
    in_raddr          = AW'(in_count - CW'(1));
    out_we            = (state == S_XFER) && rd_pending;
    out_wdata.value   = in_rdata.value;
    out_wdata.minimum = (out_count == '0) ? in_rdata.value : min_y;
    out_raddr         = AW'(out_count - CW'(1));
    if (accept && (in_item.command == mqts_pkg::CMD_ENQUEUE) && (total < CW'(DEPTH))) begin
      in_we = 1'b1;
    end
  end

  mqts_stack #(.DEPTH(DEPTH)) u_in_stack (
    .clk  (clk),
    .we   (in_we),
    .waddr(AW'(in_count)),
    .wdata(in_wdata),
    .raddr(in_raddr),
    .rdata(in_rdata)
  );

  mqts_stack #(.DEPTH(DEPTH)) u_out_stack (
    .clk  (clk),
    .we   (out_we),
    .waddr(AW'(out_count)),
    .wdata(out_wdata),
    .raddr(out_raddr),
    .rdata(out_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_count   <= '0;
      out_count  <= '0;
      rd_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= in_item.command;
            res_status <= mqts_pkg::ST_ERROR;
            res_value  <= '0;
            rd_pending <= 1'b0;
            state      <= S_DONE;
            unique case (in_item.command)
              mqts_pkg::CMD_ENQUEUE: begin
                if (total < CW'(DEPTH)) begin
                  in_min     <= in_wdata.minimum;
                  in_count   <= in_count + CW'(1);
                  res_status <= mqts_pkg::ST_OK;
                end
              end
              mqts_pkg::CMD_DEQUEUE, mqts_pkg::CMD_FRONT: begin
                if (out_count != '0) begin
                  state <= S_RD;
                end else if (in_count != '0) begin
                  state <= S_XFER;
                end
              end
              mqts_pkg::CMD_SIZE: begin
                res_status <= mqts_pkg::ST_VALUE;
                res_value  <= 32'(total);
              end
              mqts_pkg::CMD_CLEAR: begin
                in_count   <= '0;
                out_count  <= '0;
                res_status <= mqts_pkg::ST_OK;
              end
              mqts_pkg::CMD_MIN: begin
                if (out_count != '0) begin
                  state <= S_RD;
                end else if (in_count != '0) begin
                  res_status <= mqts_pkg::ST_VALUE;
                  res_value  <= in_min;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_XFER: begin
          // read of one entry overlaps the write of the one before
          if (rd_pending) begin
            xfer_min  <= out_wdata.minimum;
            out_count <= out_count + CW'(1);
          end
          if (in_count != '0) begin
            in_count   <= in_count - CW'(1);
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            if (!rd_pending) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          res_status <= mqts_pkg::ST_VALUE;
          state      <= S_DONE;
          if (op == mqts_pkg::CMD_MIN) begin
            res_value <= (in_count != '0) ? min_y : out_rdata.minimum;
          end else begin
            res_value <= out_rdata.value;
            if (op == mqts_pkg::CMD_DEQUEUE) begin
              out_count <= out_count - CW'(1);
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == S_DONE) && res_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && res_free) begin
      out_item.status    <= res_status;
      out_item.value_out <= res_value;
    end
  end

  `MQTS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, total <= CW'(DEPTH), "queue over capacity")
  `MQTS_ASSERT_IMP(a_xfer_room, clk, rst, out_we, out_count < CW'(DEPTH), "transfer past end")
  `MQTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall, "took a second command")
  `MQTS_ASSERT_IMP(a_xfer_drained, clk, rst, (state == S_RD) && ($past(state) == S_XFER),
    in_count == '0, "transfer left entries behind")

endmodule

[rtl/mqts_min_unit.sv]
// ---------------------------------------------------------------------------
// mqts_min_unit
// Shared signed 32-bit compare and select, used by push, transfer and min.
// ---------------------------------------------------------------------------
module mqts_min_unit (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] y
);

  assign y = (b < a) ? b : a;

endmodule

[rtl/mqts_stack.sv]
// ---------------------------------------------------------------------------
// mqts_stack
// Stack storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module mqts_stack #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  mqts_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output mqts_pkg::entry_t         rdata
);

  mqts_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
